[rtl/core/cbq_pkg.sv]
// shared constants, types and saturation helpers for the cascaded biquad filter
package cbq_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 26;

    // delay line format is Q8.40
    localparam int DELAY_WIDTH = 48;
    localparam int DELAY_FRAC  = 40;

    // serial accumulator, holds a floored product up to 2^50 plus headroom
    localparam int ACC_W = DELAY_WIDTH + 5;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_STAGES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 3'd6;

    localparam logic signed [ACC_W-1:0] DELAY_MAX_EXT =
        {{(ACC_W-DELAY_WIDTH+1){1'b0}}, {(DELAY_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DELAY_MIN_EXT = ~DELAY_MAX_EXT;

    typedef logic signed [DELAY_WIDTH-1:0] delay_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    // control word from the sequencer to each serial multiplier
    typedef struct packed {
        logic load;
        logic step;
        logic upper;
        logic last;
    } mul_ctl_t;

    function automatic acc_t ext_delay(input delay_t v);
        ext_delay = {{(ACC_W-DELAY_WIDTH){v[DELAY_WIDTH-1]}}, v};
    endfunction

    function automatic delay_t sat_delay(input acc_t v);
        if (v > DELAY_MAX_EXT)
            sat_delay = DELAY_MAX_EXT[DELAY_WIDTH-1:0];
        else if (v < DELAY_MIN_EXT)
            sat_delay = DELAY_MIN_EXT[DELAY_WIDTH-1:0];
        else
            sat_delay = v[DELAY_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/cbq_ifs.sv]
// valid/ready channels for input samples and filtered samples
interface cbq_in_if #(
    parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           clear_delays;

    modport source (output valid, output sample_in, output clear_delays, input ready);
    modport sink   (input valid, input sample_in, input clear_delays, output ready);
endinterface

interface cbq_out_if #(
    parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/core/cbq_mul.sv]
// bit-serial multiplier: delay-format operand times coefficient, floored and saturated
module cbq_mul #(
    parameter int COEF_WIDTH = cbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                                  clk,
    input  cbq_pkg::mul_ctl_t                     ctl,
    input  logic signed [cbq_pkg::DELAY_WIDTH-1:0] operand,
    input  logic signed [COEF_WIDTH-1:0]          coef,
    output logic signed [cbq_pkg::DELAY_WIDTH-1:0] product
);
    import cbq_pkg::*;

    acc_t                  acc_reg;
    acc_t                  acc_next;
    acc_t                  vs_reg;
    acc_t                  vs_next;
    logic [COEF_WIDTH-1:0] coef_reg;
    logic [COEF_WIDTH-1:0] coef_next;
    acc_t                  addend;
    acc_t                  sum;

    // coefficient bits come in lsb first; the sign bit carries negative weight
    always_comb
    begin
        if (coef_reg[0])
            addend = ctl.last ? -vs_reg : vs_reg;
        else
            addend = '0;
        sum = acc_reg + addend;
    end

    // fraction bits: shift the sum right (floors as it goes)
    // integer bits: keep the scale and double the operand instead
    always_comb
    begin
        acc_next  = acc_reg;
        vs_next   = vs_reg;
        coef_next = coef_reg;
        if (ctl.load)
        begin
            acc_next  = '0;
            vs_next   = ext_delay(operand);
            coef_next = coef;
        end
        else if (ctl.step)
        begin
            acc_next  = ctl.upper ? sum : (sum >>> 1);
            vs_next   = ctl.upper ? (vs_reg <<< 1) : vs_reg;
            coef_next = coef_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        vs_reg   <= vs_next;
        coef_reg <= coef_next;
    end

    assign product = sat_delay(acc_reg);

endmodule

[rtl/core/cascaded_biquad_filter.sv]
// transposed direct form II biquad, one or two stages, with serial multipliers
//
//  channel      | dir | payload                          | handshake
//  -------------+-----+----------------------------------+-----------------
//  sample_chan  | in  | sample_in, clear_delays          | valid/ready
//  result_chan  | out | sample_out                       | valid/ready
//  cfg          | in  | cfg_index, cfg_data              | cfg_we, no wait
//
// bypass: the accepted word goes through the result register to the output register
// one stage: ST_MUL_X, ST_SUM_Y, ST_MUL_Y, ST_SUM_D, ST_ROUND, then ST_DONE
// two stages: the ST_MUL_X to ST_SUM_D pass runs once per stage before ST_ROUND
// the multiply states are set by the bit-serial multipliers: one coefficient bit per cycle,
// a0/a1/a2 products in parallel, then b1/b2 products once y is known
// a new word is taken only in idle; the output register lets it in while a result waits
// reset clears control and all four delays at once, and sets a0 to 1.0, bypass on
module cascaded_biquad_filter #(
    parameter int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cbq_pkg::COEF_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEF_WIDTH-1:0]           cfg_data,
    cbq_in_if.sink                          sample_chan,
    cbq_out_if.source                       result_chan
);
    import cbq_pkg::*;

    localparam int COEF_FRAC = COEF_WIDTH - 4;
    localparam int RND_SHIFT = DELAY_FRAC - (SAMPLE_WIDTH - 1);
    localparam int CNT_W     = $clog2(COEF_WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_X = 3'd1;
    localparam logic [2:0] ST_SUM_Y = 3'd2;
    localparam logic [2:0] ST_MUL_Y = 3'd3;
    localparam logic [2:0] ST_SUM_D = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [COEF_WIDTH-1:0] A0_RESET = {3'b000, 1'b1, {COEF_FRAC{1'b0}}};

    localparam logic signed [DELAY_WIDTH:0] RND_HALF =
        {{(DELAY_WIDTH+1-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}};
    localparam logic signed [DELAY_WIDTH:0] SMP_MAX =
        {{(DELAY_WIDTH+2-SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [DELAY_WIDTH:0] SMP_MIN = ~SMP_MAX;

    // configuration
    logic signed [COEF_WIDTH-1:0] a0_reg, a1_reg, a2_reg, b1_reg, b2_reg;
    logic                         two_stages_reg;
    logic                         bypass_reg;

    // control
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             stage_reg, stage_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    delay_t                         s1_da_reg, s1_db_reg, s2_da_reg, s2_db_reg;
    delay_t                         s1_da_next, s1_db_next, s2_da_next, s2_db_next;
    delay_t                         y_reg, y_next;
    delay_t                         m1_reg, m1_next, m2_reg, m2_next;
    logic signed [SAMPLE_WIDTH-1:0] result_reg, result_next;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    logic                           accept;
    logic                           start_stage2;
    logic                           out_load;
    delay_t                         x_in;
    delay_t                         da_cur, db_cur;
    delay_t                         y_sum, da_new, db_new;
    delay_t                         mul_operand;
    logic signed [COEF_WIDTH-1:0]   coef0, coef1, coef2;
    delay_t                         prod0, prod1, prod2;
    mul_ctl_t                       mul_ctl;
    logic signed [DELAY_WIDTH:0]    rnd_sum, rnd_q;
    logic signed [SAMPLE_WIDTH-1:0] rnd_sample;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg         <= A0_RESET;
            a1_reg         <= '0;
            a2_reg         <= '0;
            b1_reg         <= '0;
            b2_reg         <= '0;
            two_stages_reg <= 1'b0;
            bypass_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_A0:    a0_reg         <= cfg_data;
                CFG_COEF_A1:    a1_reg         <= cfg_data;
                CFG_COEF_A2:    a2_reg         <= cfg_data;
                CFG_COEF_B1:    b1_reg         <= cfg_data;
                CFG_COEF_B2:    b2_reg         <= cfg_data;
                CFG_TWO_STAGES: two_stages_reg <= cfg_data[0];
                CFG_BYPASS:     bypass_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign sample_chan.ready  = (state_reg == ST_IDLE);
    assign accept             = sample_chan.valid && sample_chan.ready;
    assign result_chan.valid  = out_valid_reg;
    assign result_chan.sample_out = out_data_reg;

    // sample aligned to Q8.40
    assign x_in = {{(DELAY_WIDTH-SAMPLE_WIDTH-RND_SHIFT){sample_chan.sample_in[SAMPLE_WIDTH-1]}},
                   sample_chan.sample_in, {RND_SHIFT{1'b0}}};

    assign da_cur = stage_reg ? s2_da_reg : s1_da_reg;
    assign db_cur = stage_reg ? s2_db_reg : s1_db_reg;

    assign y_sum  = sat_delay(ext_delay(prod0) + ext_delay(da_cur));
    assign da_new = sat_delay(ext_delay(db_cur) + ext_delay(m1_reg) - ext_delay(prod0));
    assign db_new = sat_delay(ext_delay(m2_reg) - ext_delay(prod1));

    assign start_stage2 = (state_reg == ST_SUM_D) && !stage_reg && two_stages_reg;
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || result_chan.ready);

    // round half up to the sample format, then clamp
    always_comb
    begin
        rnd_sum = {y_reg[DELAY_WIDTH-1], y_reg} + RND_HALF;
        rnd_q   = rnd_sum >>> RND_SHIFT;
        if (rnd_q > SMP_MAX)
            rnd_sample = SMP_MAX[SAMPLE_WIDTH-1:0];
        else if (rnd_q < SMP_MIN)
            rnd_sample = SMP_MIN[SAMPLE_WIDTH-1:0];
        else
            rnd_sample = rnd_q[SAMPLE_WIDTH-1:0];
    end

    // multiplier lanes: a0/a1/a2 on x (stage two: on the first stage's y), then b1/b2 on y
    always_comb
    begin
        mul_ctl.load  = (accept && !bypass_reg) || (state_reg == ST_SUM_Y) || start_stage2;
        mul_ctl.step  = (state_reg == ST_MUL_X) || (state_reg == ST_MUL_Y);
        mul_ctl.upper = (bit_cnt_reg >= CNT_W'(COEF_FRAC));
        mul_ctl.last  = (bit_cnt_reg == CNT_W'(COEF_WIDTH - 1));

        priority if (state_reg == ST_SUM_Y)
            mul_operand = y_sum;
        else if (state_reg == ST_SUM_D)
            mul_operand = y_reg;
        else
            mul_operand = x_in;

        if (state_reg == ST_SUM_Y)
        begin
            coef0 = b1_reg;
            coef1 = b2_reg;
            coef2 = '0;
        end
        else
        begin
            coef0 = a0_reg;
            coef1 = a1_reg;
            coef2 = a2_reg;
        end
    end

    cbq_mul #(.COEF_WIDTH(COEF_WIDTH)) u_mul0 (
        .clk     (clk),
        .ctl     (mul_ctl),
        .operand (mul_operand),
        .coef    (coef0),
        .product (prod0)
    );

    cbq_mul #(.COEF_WIDTH(COEF_WIDTH)) u_mul1 (
        .clk     (clk),
        .ctl     (mul_ctl),
        .operand (mul_operand),
        .coef    (coef1),
        .product (prod1)
    );

    cbq_mul #(.COEF_WIDTH(COEF_WIDTH)) u_mul2 (
        .clk     (clk),
        .ctl     (mul_ctl),
        .operand (mul_operand),
        .coef    (coef2),
        .product (prod2)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg;
        s1_da_next     = s1_da_reg;
        s1_db_next     = s1_db_reg;
        s2_da_next     = s2_da_reg;
        s2_db_next     = s2_db_reg;
        y_next         = y_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        result_next    = result_reg;
        out_data_next  = out_data_reg;

        if (mul_ctl.load)
            bit_cnt_next = '0;
        else if (mul_ctl.step)
            bit_cnt_next = bit_cnt_reg + 1'b1;

        if (result_chan.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    stage_next = 1'b0;
                    if (sample_chan.clear_delays)
                    begin
                        s1_da_next = '0;
                        s1_db_next = '0;
                        s2_da_next = '0;
                        s2_db_next = '0;
                    end
                    if (bypass_reg)
                    begin
                        result_next = sample_chan.sample_in;
                        state_next  = ST_DONE;
                    end
                    else
                        state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                if (mul_ctl.last)
                    state_next = ST_SUM_Y;
            end
            ST_SUM_Y:
            begin
                // keep the a1/a2 products, lanes are reloaded for the feedback terms
                y_next     = y_sum;
                m1_next    = prod1;
                m2_next    = prod2;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                if (mul_ctl.last)
                    state_next = ST_SUM_D;
            end
            ST_SUM_D:
            begin
                if (stage_reg)
                begin
                    s2_da_next = da_new;
                    s2_db_next = db_new;
                end
                else
                begin
                    s1_da_next = da_new;
                    s1_db_next = db_new;
                end
                if (start_stage2)
                begin
                    stage_next = 1'b1;
                    state_next = ST_MUL_X;
                end
                else
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                result_next = rnd_sample;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_data_next  = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            stage_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_da_reg     <= '0;
            s1_db_reg     <= '0;
            s2_da_reg     <= '0;
            s2_db_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
            s1_da_reg     <= s1_da_next;
            s1_db_reg     <= s1_db_next;
            s2_da_reg     <= s2_da_next;
            s2_db_reg     <= s2_db_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        m1_reg       <= m1_next;
        m2_reg       <= m2_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    // a filtered word starts the serial pass with the bit counter at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !bypass_reg) |=> (state_reg == ST_MUL_X) && (bit_cnt_reg == '0))
        else $error("multiply pass did not start after accept");

    // the bit counter never runs past the coefficient width while multiplying
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL_X) || (state_reg == ST_MUL_Y))
            |-> (bit_cnt_reg <= CNT_W'(COEF_WIDTH - 1)))
        else $error("bit counter out of range");

    // updating the first stage leaves the second stage delays alone
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM_D) && !stage_reg) |=> ($stable(s2_da_reg) && $stable(s2_db_reg)))
        else $error("stage two delays changed during stage one update");

    // a finished result moves into the output register and the block goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not handed to the output register");

endmodule
